// ===== hw/rtl/fpha_pkg.sv =====
`timescale 1ns / 1ps

package fpha_pkg;

   localparam int unsigned HEAP_INCREMENT = 4096;
   localparam int unsigned HEADER_BYTES   = 16;
   localparam int unsigned MAX_BLOCKS     = 64;
   localparam int unsigned HEAP_MAX_BYTES = 1048576;

   localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned ADDR_W = 20;
   localparam int unsigned SIZE_W = 21;
   localparam int unsigned SUM_W  = 22;
   localparam int unsigned ENT_W  = ADDR_W + SIZE_W;
   localparam int unsigned CSR_W  = 2;

   localparam logic [CSR_W-1:0] CSR_FIT_POLICY = 2'd0;
   localparam logic [CSR_W-1:0] CSR_HEAP_LIMIT = 2'd1;

   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_QUERY   = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_HEAP    = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_BAD_ADDR   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SCAN_SEARCH,
      SCAN_GROW,
      SCAN_NEIGH,
      SCAN_SUM,
      SCAN_USED
   } scan_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_GROW,
      S_SC_RD,
      S_SC_CK,
      S_TAKE,
      S_USED_WR,
      S_SHD_RD,
      S_SHD_WR,
      S_SHU_RD,
      S_SHU_WR,
      S_HEAD_WR,
      S_UMV_RD,
      S_UMV_WR,
      S_REM1,
      S_REM2,
      S_PUSH,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

// ===== hw/rtl/fpha_ram.sv =====
`timescale 1ns / 1ps

module fpha_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 41
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fit_policy_heap_allocator.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | func, request_bytes, release_address
// rsp     | out       | rsp_valid/stall   | block_address, status, free_bytes
// csr     | in        | csr_write         | csr_index, csr_data
//
// One word at a time; each pass over the free or used list reads one entry at a time
// through that list's single RAM read port. Reset clears counts and control; no
// clearing pass. rsp_stall holds the output register, and a finished result waits
// in S_RESULT while it is held; the next req word is taken while a result waits
// in the output register.

module fit_policy_heap_allocator import fpha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [SIZE_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0] req_release_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_block_address,
   output logic [1:0]        rsp_status,
   output logic [SIZE_W-1:0] rsp_free_bytes,
   input  logic              csr_write,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0] csr_data
);

   state_type state_ff, state_in, ret_ff, ret_in;
   scan_type  mode_ff, mode_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, sh_ff, sh_in;
   logic [CNT_W-1:0]  fcount_ff, fcount_in, ucount_ff, ucount_in;
   logic [SIZE_W-1:0] heap_ff, heap_in;
   logic              started_ff, started_in, grow_init_ff, grow_init_in;
   logic              found_ff, found_in, push_grow_ff, push_grow_in;
   logic [IDX_W-1:0]  pick_ff, pick_in, rel_idx_ff, rel_idx_in;
   logic [ADDR_W-1:0] pstart_ff, pstart_in;
   logic [SIZE_W-1:0] psize_ff, psize_in, take_size_ff, take_size_in;
   logic [SUM_W-1:0]  need_ff, need_in;
   logic [ADDR_W-1:0] rel_addr_ff, rel_addr_in, rel_start_ff, rel_start_in;
   logic [SIZE_W-1:0] rel_size_ff, rel_size_in;
   logic              lv_ff, lv_in, rv_ff, rv_in, rm2v_ff, rm2v_in;
   logic [IDX_W-1:0]  lidx_ff, lidx_in, ridx_ff, ridx_in, rm2_ff, rm2_in;
   logic [ADDR_W-1:0] lstart_ff, lstart_in;
   logic [SIZE_W-1:0] lsize_ff, lsize_in, rsize_ff, rsize_in;
   entry_type         nb_ff, nb_in;
   logic [SIZE_W-1:0] sum_ff, sum_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;
   logic [SIZE_W-1:0] res_fb_ff, res_fb_in;
   logic [1:0]        policy_ff, policy_in;
   logic [SIZE_W-1:0] limit_ff, limit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0] rsp_fb_ff, rsp_fb_in;

   logic             f_we, u_we;
   logic [IDX_W-1:0] f_waddr, f_raddr, u_waddr, u_raddr;
   entry_type        f_wdata, u_wdata, e, ue;
   logic [ENT_W-1:0] f_rdata, u_rdata;

   logic [SUM_W-1:0] grow_sum, lim, e_end, ue_hdr, rel_end, rem;
   logic [CNT_W-1:0] bound;

   fpha_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(ENT_W)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   fpha_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(ENT_W)) u_used_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_waddr),
      .wr_data (u_wdata),
      .rd_addr (u_raddr),
      .rd_data (u_rdata)
   );

   assign e        = entry_type'(f_rdata);
   assign ue       = entry_type'(u_rdata);
   assign grow_sum = SUM_W'(heap_ff) + SUM_W'(HEAP_INCREMENT);
   assign lim      = (SUM_W'(limit_ff) < SUM_W'(HEAP_MAX_BYTES)) ?
                     SUM_W'(limit_ff) : SUM_W'(HEAP_MAX_BYTES);
   assign e_end    = SUM_W'(e.start) + SUM_W'(e.size);
   assign ue_hdr   = SUM_W'(ue.start) + SUM_W'(HEADER_BYTES);
   assign rel_end  = SUM_W'(rel_start_ff) + SUM_W'(rel_size_ff);
   assign rem      = SUM_W'(psize_ff) - need_ff;
   assign bound    = (mode_ff == SCAN_USED) ? ucount_ff : fcount_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      sh_in         = sh_ff;
      fcount_in     = fcount_ff;
      ucount_in     = ucount_ff;
      heap_in       = heap_ff;
      started_in    = started_ff;
      grow_init_in  = grow_init_ff;
      found_in      = found_ff;
      push_grow_in  = push_grow_ff;
      pick_in       = pick_ff;
      rel_idx_in    = rel_idx_ff;
      pstart_in     = pstart_ff;
      psize_in      = psize_ff;
      take_size_in  = take_size_ff;
      need_in       = need_ff;
      rel_addr_in   = rel_addr_ff;
      rel_start_in  = rel_start_ff;
      rel_size_in   = rel_size_ff;
      lv_in         = lv_ff;
      rv_in         = rv_ff;
      rm2v_in       = rm2v_ff;
      lidx_in       = lidx_ff;
      ridx_in       = ridx_ff;
      rm2_in        = rm2_ff;
      lstart_in     = lstart_ff;
      lsize_in      = lsize_ff;
      rsize_in      = rsize_ff;
      nb_in         = nb_ff;
      sum_in        = sum_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_fb_in     = res_fb_ff;
      policy_in     = policy_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fb_in     = rsp_fb_ff;
      f_we    = 1'b0;
      f_waddr = '0;
      f_wdata = '0;
      f_raddr = '0;
      u_we    = 1'b0;
      u_waddr = '0;
      u_wdata = '0;
      u_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               need_in       = SUM_W'(req_request_bytes) + SUM_W'(HEADER_BYTES);
               rel_addr_in   = req_release_address;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               res_fb_in     = '0;
               idx_in        = '0;
               found_in      = 1'b0;
               case (func_type'(req_func))
                  FUNC_ALLOC: begin
                     if (ucount_ff == CNT_W'(MAX_BLOCKS)) begin
                        res_status_in = ST_TABLE_FULL;
                        state_in      = S_RESULT;
                     end else if (!started_ff) begin
                        started_in   = 1'b1;
                        grow_init_in = 1'b1;
                        state_in     = S_GROW;
                     end else begin
                        mode_in      = SCAN_SEARCH;
                        grow_init_in = 1'b0;
                        state_in     = S_SC_RD;
                     end
                  end
                  FUNC_RELEASE: begin
                     mode_in  = SCAN_USED;
                     state_in = S_SC_RD;
                  end
                  FUNC_QUERY: begin
                     mode_in  = SCAN_SUM;
                     sum_in   = '0;
                     state_in = S_SC_RD;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end

         S_GROW: begin
            if (grow_sum > lim) begin
               if (grow_init_ff) begin
                  idx_in       = '0;
                  mode_in      = SCAN_SEARCH;
                  found_in     = 1'b0;
                  grow_init_in = 1'b0;
                  state_in     = S_SC_RD;
               end else begin
                  res_status_in = ST_NO_HEAP;
                  state_in      = S_RESULT;
               end
            end else begin
               idx_in   = '0;
               mode_in  = SCAN_GROW;
               state_in = S_SC_RD;
            end
         end

         S_SC_RD: begin
            if (idx_ff < bound) begin
               f_raddr  = idx_ff[IDX_W-1:0];
               u_raddr  = idx_ff[IDX_W-1:0];
               state_in = S_SC_CK;
            end else begin
               case (mode_ff)
                  SCAN_SEARCH: begin
                     state_in = found_ff ? S_TAKE : S_GROW;
                  end
                  SCAN_GROW: begin
                     if (fcount_ff == CNT_W'(MAX_BLOCKS)) begin
                        if (grow_init_ff) begin
                           idx_in       = '0;
                           mode_in      = SCAN_SEARCH;
                           found_in     = 1'b0;
                           grow_init_in = 1'b0;
                           state_in     = S_SC_RD;
                        end else begin
                           res_status_in = ST_NO_HEAP;
                           state_in      = S_RESULT;
                        end
                     end else begin
                        nb_in.start  = heap_ff[ADDR_W-1:0];
                        nb_in.size   = SIZE_W'(HEAP_INCREMENT);
                        push_grow_in = 1'b1;
                        sh_in        = fcount_ff;
                        state_in     = S_SHU_RD;
                     end
                  end
                  SCAN_NEIGH: begin
                     state_in = S_REM1;
                  end
                  SCAN_SUM: begin
                     res_fb_in = sum_ff;
                     state_in  = S_RESULT;
                  end
                  default: begin
                     res_status_in = ST_BAD_ADDR;
                     state_in      = S_RESULT;
                  end
               endcase
            end
         end

         S_SC_CK: begin
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_SC_RD;
            case (mode_ff)
               SCAN_SEARCH: begin
                  if (SUM_W'(e.size) >= need_ff) begin
                     if (!found_ff) begin
                        found_in  = 1'b1;
                        pick_in   = idx_ff[IDX_W-1:0];
                        pstart_in = e.start;
                        psize_in  = e.size;
                        if (!(policy_ff inside {POLICY_BEST, POLICY_WORST})) begin
                           state_in = S_TAKE;
                        end
                     end else if ((policy_ff == POLICY_BEST && e.size < psize_ff) ||
                                  (policy_ff == POLICY_WORST && e.size > psize_ff)) begin
                        pick_in   = idx_ff[IDX_W-1:0];
                        pstart_in = e.start;
                        psize_in  = e.size;
                     end
                  end
               end
               SCAN_GROW: begin
                  if (e_end == SUM_W'(heap_ff)) begin
                     f_we         = 1'b1;
                     f_waddr      = idx_ff[IDX_W-1:0];
                     f_wdata      = '{start: e.start,
                                      size: e.size + SIZE_W'(HEAP_INCREMENT)};
                     heap_in      = SIZE_W'(grow_sum);
                     idx_in       = '0;
                     mode_in      = SCAN_SEARCH;
                     found_in     = 1'b0;
                     grow_init_in = 1'b0;
                  end
               end
               SCAN_NEIGH: begin
                  if (!rv_ff && SUM_W'(e.start) == rel_end) begin
                     rv_in    = 1'b1;
                     ridx_in  = idx_ff[IDX_W-1:0];
                     rsize_in = e.size;
                  end
                  if (!lv_ff && e_end == SUM_W'(rel_start_ff)) begin
                     lv_in     = 1'b1;
                     lidx_in   = idx_ff[IDX_W-1:0];
                     lstart_in = e.start;
                     lsize_in  = e.size;
                  end
               end
               SCAN_SUM: begin
                  if (e.size > SIZE_W'(HEADER_BYTES)) begin
                     sum_in = sum_ff + e.size - SIZE_W'(HEADER_BYTES);
                  end
               end
               default: begin
                  if (ue_hdr == SUM_W'(rel_addr_ff)) begin
                     rel_idx_in   = idx_ff[IDX_W-1:0];
                     rel_start_in = ue.start;
                     rel_size_in  = ue.size;
                     state_in     = S_UMV_RD;
                  end
               end
            endcase
         end

         S_TAKE: begin
            if (rem > SUM_W'(HEADER_BYTES)) begin
               f_we         = 1'b1;
               f_waddr      = pick_ff;
               f_wdata      = '{start: ADDR_W'(SUM_W'(pstart_ff) + need_ff),
                                size: SIZE_W'(rem)};
               take_size_in = SIZE_W'(need_ff);
               state_in     = S_USED_WR;
            end else begin
               take_size_in = psize_ff;
               sh_in        = CNT_W'(pick_ff);
               ret_in       = S_USED_WR;
               state_in     = S_SHD_RD;
            end
         end

         S_USED_WR: begin
            u_we          = 1'b1;
            u_waddr       = ucount_ff[IDX_W-1:0];
            u_wdata       = '{start: pstart_ff, size: take_size_ff};
            ucount_in     = ucount_ff + CNT_W'(1);
            res_addr_in   = pstart_ff + ADDR_W'(HEADER_BYTES);
            res_status_in = ST_OK;
            state_in      = S_RESULT;
         end

         S_SHD_RD: begin
            if (sh_ff + CNT_W'(1) < fcount_ff) begin
               f_raddr  = IDX_W'(sh_ff + CNT_W'(1));
               state_in = S_SHD_WR;
            end else begin
               fcount_in = fcount_ff - CNT_W'(1);
               state_in  = ret_ff;
            end
         end

         S_SHD_WR: begin
            f_we     = 1'b1;
            f_waddr  = sh_ff[IDX_W-1:0];
            f_wdata  = e;
            sh_in    = sh_ff + CNT_W'(1);
            state_in = S_SHD_RD;
         end

         S_SHU_RD: begin
            if (sh_ff != '0) begin
               f_raddr  = IDX_W'(sh_ff - CNT_W'(1));
               state_in = S_SHU_WR;
            end else begin
               state_in = S_HEAD_WR;
            end
         end

         S_SHU_WR: begin
            f_we     = 1'b1;
            f_waddr  = sh_ff[IDX_W-1:0];
            f_wdata  = e;
            sh_in    = sh_ff - CNT_W'(1);
            state_in = S_SHU_RD;
         end

         S_HEAD_WR: begin
            f_we      = 1'b1;
            f_waddr   = '0;
            f_wdata   = nb_ff;
            fcount_in = fcount_ff + CNT_W'(1);
            if (push_grow_ff) begin
               heap_in      = SIZE_W'(grow_sum);
               idx_in       = '0;
               mode_in      = SCAN_SEARCH;
               found_in     = 1'b0;
               grow_init_in = 1'b0;
               state_in     = S_SC_RD;
            end else begin
               state_in = S_RESULT;
            end
         end

         S_UMV_RD: begin
            u_raddr  = IDX_W'(ucount_ff - CNT_W'(1));
            state_in = S_UMV_WR;
         end

         S_UMV_WR: begin
            u_we      = 1'b1;
            u_waddr   = rel_idx_ff;
            u_wdata   = ue;
            ucount_in = ucount_ff - CNT_W'(1);
            idx_in    = '0;
            lv_in     = 1'b0;
            rv_in     = 1'b0;
            mode_in   = SCAN_NEIGH;
            state_in  = S_SC_RD;
         end

         S_REM1: begin
            nb_in.start = lv_ff ? lstart_ff : rel_start_ff;
            nb_in.size  = rel_size_ff + (rv_ff ? rsize_ff : '0) + (lv_ff ? lsize_ff : '0);
            ret_in      = S_REM2;
            if (lv_ff && (!rv_ff || lidx_ff > ridx_ff)) begin
               sh_in    = CNT_W'(lidx_ff);
               rm2v_in  = rv_ff;
               rm2_in   = ridx_ff;
               state_in = S_SHD_RD;
            end else if (rv_ff) begin
               sh_in    = CNT_W'(ridx_ff);
               rm2v_in  = lv_ff;
               rm2_in   = lidx_ff;
               state_in = S_SHD_RD;
            end else begin
               state_in = S_PUSH;
            end
         end

         S_REM2: begin
            if (rm2v_ff) begin
               sh_in    = CNT_W'(rm2_ff);
               ret_in   = S_PUSH;
               state_in = S_SHD_RD;
            end else begin
               state_in = S_PUSH;
            end
         end

         S_PUSH: begin
            push_grow_in = 1'b0;
            if (fcount_ff < CNT_W'(MAX_BLOCKS)) begin
               sh_in    = fcount_ff;
               state_in = S_SHU_RD;
            end else begin
               state_in = S_RESULT;
            end
         end

         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_fb_in     = res_fb_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write && (csr_index == CSR_FIT_POLICY || csr_index == CSR_HEAP_LIMIT)) begin
         if (csr_index == CSR_FIT_POLICY) begin
            policy_in = csr_data[1:0];
         end else begin
            limit_in = csr_data;
         end
         fcount_in  = '0;
         ucount_in  = '0;
         heap_in    = '0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fcount_ff    <= '0;
         ucount_ff    <= '0;
         heap_ff      <= '0;
         started_ff   <= 1'b0;
         policy_ff    <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcount_ff    <= fcount_in;
         ucount_ff    <= ucount_in;
         heap_ff      <= heap_in;
         started_ff   <= started_in;
         policy_ff    <= policy_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      grow_init_ff  <= grow_init_in;
      found_ff      <= found_in;
      push_grow_ff  <= push_grow_in;
      pick_ff       <= pick_in;
      rel_idx_ff    <= rel_idx_in;
      pstart_ff     <= pstart_in;
      psize_ff      <= psize_in;
      take_size_ff  <= take_size_in;
      need_ff       <= need_in;
      rel_addr_ff   <= rel_addr_in;
      rel_start_ff  <= rel_start_in;
      rel_size_ff   <= rel_size_in;
      lv_ff         <= lv_in;
      rv_ff         <= rv_in;
      rm2v_ff       <= rm2v_in;
      lidx_ff       <= lidx_in;
      ridx_ff       <= ridx_in;
      rm2_ff        <= rm2_in;
      lstart_ff     <= lstart_in;
      lsize_ff      <= lsize_in;
      rsize_ff      <= rsize_in;
      nb_ff         <= nb_in;
      sum_ff        <= sum_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_fb_ff     <= res_fb_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fb_ff     <= rsp_fb_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_bytes    = rsp_fb_ff;

endmodule

// ===== hw/rtl/fpha_chk.sv =====
`timescale 1ns / 1ps

module fpha_chk import fpha_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [ADDR_W-1:0] rsp_block_address,
   input logic [1:0]        rsp_status,
   input logic [SIZE_W-1:0] rsp_free_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word after reset");

   a_addr_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_block_address == '0)
      else $error("address on failed word");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_free_bytes != '0 |->
         rsp_status == ST_OK && rsp_block_address == '0 &&
         rsp_free_bytes <= SIZE_W'(HEAP_MAX_BYTES))
      else $error("free byte count inconsistent");

endmodule

bind fit_policy_heap_allocator fpha_chk u_fpha_chk (.*);

// ===== sim/fit_policy_heap_allocator_tb.sv =====
`timescale 1ns / 1ps

module fit_policy_heap_allocator_tb;
   import fpha_pkg::*;

   class heap_scoreboard;
      typedef struct {
         logic [ADDR_W-1:0] block_address;
         status_type        status;
         logic [SIZE_W-1:0] free_bytes;
      } word_type;

      int unsigned policy, limit;
      int unsigned free_base[MAX_BLOCKS], free_len[MAX_BLOCKS], free_cnt;
      int unsigned used_base[MAX_BLOCKS], used_len[MAX_BLOCKS], used_cnt;
      int unsigned heap_top;
      bit          started;
      word_type    awaited[$];
      int          errors, checked, n_ok, n_no_heap, n_full, n_bad;

      function void empty_heap();
         free_cnt = 0;
         used_cnt = 0;
         heap_top = 0;
         started  = 0;
      endfunction

      function void write_reg(logic [CSR_W-1:0] idx, logic [SIZE_W-1:0] val);
         if (idx == CSR_FIT_POLICY) policy = val[1:0];
         else if (idx == CSR_HEAP_LIMIT) limit = val;
         else return;
         empty_heap();
      endfunction

      function void drop_free(int unsigned i);
         for (int unsigned k = i; k + 1 < free_cnt; k++) begin
            free_base[k] = free_base[k+1];
            free_len[k]  = free_len[k+1];
         end
         free_cnt--;
      endfunction

      function bit push_free(int unsigned s, int unsigned z);
         if (free_cnt >= MAX_BLOCKS) return 0;
         for (int unsigned k = free_cnt; k > 0; k--) begin
            free_base[k] = free_base[k-1];
            free_len[k]  = free_len[k-1];
         end
         free_base[0] = s;
         free_len[0]  = z;
         free_cnt++;
         return 1;
      endfunction

      function bit grow_heap();
         int unsigned cap;
         cap = limit < HEAP_MAX_BYTES ? limit : HEAP_MAX_BYTES;
         if (heap_top + HEAP_INCREMENT > cap) return 0;
         for (int unsigned i = 0; i < free_cnt; i++)
            if (free_base[i] + free_len[i] == heap_top) begin
               free_len[i] += HEAP_INCREMENT;
               heap_top += HEAP_INCREMENT;
               return 1;
            end
         if (!push_free(heap_top, HEAP_INCREMENT)) return 0;
         heap_top += HEAP_INCREMENT;
         return 1;
      endfunction

      function int find_fit(int unsigned need);
         int pick;
         pick = -1;
         for (int unsigned i = 0; i < free_cnt; i++) begin
            if (free_len[i] < need) continue;
            if (pick < 0) begin
               pick = i;
               if (policy != POLICY_BEST && policy != POLICY_WORST) return pick;
            end else if (policy == POLICY_BEST && free_len[i] < free_len[pick])
               pick = i;
            else if (policy == POLICY_WORST && free_len[i] > free_len[pick])
               pick = i;
         end
         return pick;
      endfunction

      function status_type allocate(int unsigned req, output int unsigned addr);
         int unsigned need, s, z;
         int pick;
         need = req + HEADER_BYTES;
         addr = 0;
         if (used_cnt >= MAX_BLOCKS) return ST_TABLE_FULL;
         if (!started) begin
            void'(grow_heap());
            started = 1;
         end
         pick = find_fit(need);
         while (pick < 0) begin
            if (!grow_heap()) return ST_NO_HEAP;
            pick = find_fit(need);
         end
         s = free_base[pick];
         z = free_len[pick];
         if (z - need > HEADER_BYTES) begin
            free_base[pick] = s + need;
            free_len[pick]  = z - need;
            z = need;
         end else drop_free(pick);
         used_base[used_cnt] = s;
         used_len[used_cnt]  = z;
         used_cnt++;
         addr = s + HEADER_BYTES;
         return ST_OK;
      endfunction

      function status_type release_block(int unsigned addr);
         int unsigned i, s, z, e;
         int lft, rgt;
         lft = -1;
         rgt = -1;
         for (i = 0; i < used_cnt; i++)
            if (used_base[i] + HEADER_BYTES == addr) break;
         if (i >= used_cnt) return ST_BAD_ADDR;
         s = used_base[i];
         z = used_len[i];
         used_base[i] = used_base[used_cnt-1];
         used_len[i]  = used_len[used_cnt-1];
         used_cnt--;
         e = s + z;
         for (i = 0; i < free_cnt; i++) begin
            if (rgt < 0 && free_base[i] == e) rgt = i;
            if (lft < 0 && free_base[i] + free_len[i] == s) lft = i;
         end
         if (rgt >= 0) z += free_len[rgt];
         if (lft >= 0) begin
            s = free_base[lft];
            z += free_len[lft];
         end
         if (lft > rgt) begin
            drop_free(lft);
            if (rgt >= 0) drop_free(rgt);
         end else if (rgt >= 0) begin
            drop_free(rgt);
            if (lft >= 0) drop_free(lft);
         end
         void'(push_free(s, z));
         return ST_OK;
      endfunction

      function void note_request(logic [1:0] f, logic [SIZE_W-1:0] req,
                                 logic [ADDR_W-1:0] rel);
         word_type    w;
         int unsigned a, sum;
         a = 0;
         sum = 0;
         w.status = ST_OK;
         if (f == FUNC_ALLOC) w.status = allocate(req, a);
         else if (f == FUNC_RELEASE) w.status = release_block(rel);
         else if (f == FUNC_QUERY)
            for (int unsigned i = 0; i < free_cnt; i++)
               if (free_len[i] > HEADER_BYTES) sum += free_len[i] - HEADER_BYTES;
         w.block_address = a[ADDR_W-1:0];
         w.free_bytes    = sum[SIZE_W-1:0];
         case (w.status)
            ST_OK:         n_ok++;
            ST_NO_HEAP:    n_no_heap++;
            ST_TABLE_FULL: n_full++;
            default:       n_bad++;
         endcase
         awaited.push_back(w);
      endfunction

      function void check_result(logic [ADDR_W-1:0] a, logic [1:0] st,
                                 logic [SIZE_W-1:0] fb);
         word_type w;
         if (awaited.size() == 0) begin
            $error("unexpected result word: address %0d status %0d free %0d", a, st, fb);
            errors++;
            return;
         end
         w = awaited.pop_front();
         checked++;
         if (a !== w.block_address) begin
            $error("block_address: expected %0d actual %0d", w.block_address, a);
            errors++;
         end
         if (st !== w.status) begin
            $error("status: expected %0d actual %0d", w.status, st);
            errors++;
         end
         if (fb !== w.free_bytes) begin
            $error("free_bytes: expected %0d actual %0d", w.free_bytes, fb);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [1:0]        req_func = FUNC_QUERY;
   logic [SIZE_W-1:0] req_request_bytes = 0;
   logic [ADDR_W-1:0] req_release_address = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [ADDR_W-1:0] rsp_block_address;
   logic [1:0]        rsp_status;
   logic [SIZE_W-1:0] rsp_free_bytes;
   logic              csr_write = 0;
   logic [CSR_W-1:0]  csr_index = CSR_FIT_POLICY;
   logic [SIZE_W-1:0] csr_data = 0;

   heap_scoreboard sb = new();
   int unsigned    send_idle = 0, recv_idle = 0;

   fit_policy_heap_allocator u_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_block_address, rsp_status, rsp_free_bytes);
      rsp_stall <= $urandom_range(99) < recv_idle;
   end

   task automatic send_word(logic [1:0] f, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] rel);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid           <= 1;
      req_func            <= f;
      req_request_bytes   <= req;
      req_release_address <= rel;
      do @(posedge clock); while (req_stall);
      sb.note_request(f, req, rel);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] idx, logic [SIZE_W-1:0] val);
      req_valid <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.write_reg(idx, val);
   endtask

   task automatic send_random();
      int unsigned r, sz;
      r = $urandom_range(99);
      if (r < 50 || (r < 85 && sb.used_cnt == 0)) begin
         sz = $urandom_range(99);
         if (sz < 70) sz = $urandom_range(300);
         else if (sz < 95) sz = $urandom_range(3000);
         else if (sz < 99) sz = $urandom_range(9000);
         else sz = $urandom_range(HEAP_MAX_BYTES);
         send_word(FUNC_ALLOC, sz, $urandom);
      end else if (r < 85)
         send_word(FUNC_RELEASE, $urandom,
                   sb.used_base[$urandom_range(sb.used_cnt - 1)] + HEADER_BYTES);
      else if (r < 92) send_word(FUNC_QUERY, $urandom, $urandom);
      else if (r < 97) send_word(FUNC_RELEASE, $urandom, $urandom);
      else send_word(FUNC_NONE, $urandom, $urandom);
   endtask

   initial begin
      int unsigned limits[6] = '{8192, 65536, 1048576, 20480, 32768, 262144};
      int unsigned keep[$];
      sb.write_reg(CSR_FIT_POLICY, 0);
      sb.write_reg(CSR_HEAP_LIMIT, 0);
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_reg(CSR_HEAP_LIMIT, 0);
      send_word(FUNC_ALLOC, 0, 0);
      send_word(FUNC_QUERY, 0, 0);
      send_word(FUNC_RELEASE, 0, 20'hFFFFF);
      send_word(FUNC_NONE, 21'h1FFFFF, 20'hFFFFF);
      write_reg(CSR_FIT_POLICY, 3);
      write_reg(CSR_HEAP_LIMIT, HEAP_MAX_BYTES);
      send_word(FUNC_ALLOC, HEAP_MAX_BYTES, 0);
      send_word(FUNC_ALLOC, 21'hFFFFF, 0);
      send_word(FUNC_ALLOC, 0, 0);
      send_word(FUNC_ALLOC, 4000, 0);
      send_word(FUNC_ALLOC, 100, 0);
      send_word(FUNC_QUERY, 0, 0);
      send_word(FUNC_RELEASE, 0, 16 + 16);
      send_word(FUNC_RELEASE, 0, 16);
      send_word(FUNC_RELEASE, 0, 16);
      send_word(FUNC_RELEASE, 0, 16 + 16 + 16 + 4000);
      send_word(FUNC_QUERY, 0, 0);
      for (int i = 0; i <= MAX_BLOCKS; i++) begin
         send_word(FUNC_ALLOC, 8, 0);
         if (i % 3 == 0) keep.push_back(sb.used_base[sb.used_cnt-1] + HEADER_BYTES);
      end
      foreach (keep[i]) send_word(FUNC_RELEASE, 0, keep[i]);
      send_word(FUNC_QUERY, 0, 0);

      for (int seg = 0; seg < 6; seg++) begin
         send_idle = seg < 2 ? 23 : seg < 4 ? 48 : 0;
         recv_idle = seg < 2 ? 48 : seg < 4 ? 23 : 0;
         write_reg(CSR_FIT_POLICY, seg % 3);
         write_reg(CSR_HEAP_LIMIT, limits[seg]);
         repeat (258) send_random();
      end
      req_valid <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d results: %0d ok, %0d out of heap, %0d table full, %0d bad release",
               sb.checked, sb.n_ok, sb.n_no_heap, sb.n_full, sb.n_bad);
      $display("all fit policies, heap limits from 0 to 1 MiB, varied stall and idle mixes");
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("fit_policy_heap_allocator test passed");
      else
         $display("fit_policy_heap_allocator test failed");
      $finish;
   end

   initial begin
      #400ms;
      $display("fit_policy_heap_allocator test failed");
      $finish;
   end

endmodule
